[design/uct_pkg.sv]
// Shared widths, character constants, tag and status codes for the URL component tagger.
`default_nettype none

package uct_pkg;

   localparam int BYTE_W   = 8;
   localparam int TAG_W    = 3;
   localparam int STATUS_W = 2;

   localparam logic [BYTE_W-1:0] CHAR_COLON    = 8'h3A;
   localparam logic [BYTE_W-1:0] CHAR_SLASH    = 8'h2F;
   localparam logic [BYTE_W-1:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [BYTE_W-1:0] CHAR_RBRACKET = 8'h5D;
   localparam logic [BYTE_W-1:0] CHAR_QUESTION = 8'h3F;
   localparam logic [BYTE_W-1:0] CHAR_HASH     = 8'h23;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_Z  = 8'h5A;
   localparam logic [BYTE_W-1:0] CASE_BIT      = 8'h20;

   localparam logic [TAG_W-1:0] TAG_SCHEME = 3'd0;
   localparam logic [TAG_W-1:0] TAG_DELIM  = 3'd1;
   localparam logic [TAG_W-1:0] TAG_HOST   = 3'd2;
   localparam logic [TAG_W-1:0] TAG_PORT   = 3'd3;
   localparam logic [TAG_W-1:0] TAG_PATH   = 3'd4;
   localparam logic [TAG_W-1:0] TAG_QUERY  = 3'd5;
   localparam logic [TAG_W-1:0] TAG_FRAG   = 3'd6;
   localparam logic [TAG_W-1:0] TAG_DROP   = 3'd7;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOCOLON = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SLASHES = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BRACKET = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic [TAG_W-1:0]    out_tag;
      logic                out_last;
      logic [STATUS_W-1:0] out_status;
   } rsp_item_type;

endpackage

`default_nettype wire

[design/uct_channels.sv]
// Valid/ready channel interfaces for the request bytes and the tagged results.
`default_nettype none

interface uct_req_if;
   logic                       valid;
   logic                       ready;
   logic [uct_pkg::BYTE_W-1:0] in_byte;
   logic                       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface uct_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [uct_pkg::BYTE_W-1:0]   out_byte;
   logic [uct_pkg::TAG_W-1:0]    out_tag;
   logic                         out_last;
   logic [uct_pkg::STATUS_W-1:0] out_status;

   modport source (output valid, output out_byte, output out_tag, output out_last,
                   output out_status, input ready);
   modport sink   (input valid, input out_byte, input out_tag, input out_last,
                   input out_status, output ready);
endinterface

`default_nettype wire

[design/url_component_tagger.sv]
// Top level of the URL component tagger: phase machine and two-entry result buffer.
//
//   channel   direction   payload                                       handshake
//   req_chan  in          in_byte[7:0], in_last                         valid / ready
//   rsp_chan  out         out_byte[7:0], out_tag[2:0], out_last,        valid / ready
//                         out_status[1:0]
//
// One byte per cycle while req_chan.ready is high: each byte is tagged by the phase machine
// in the cycle it is accepted, and its result is registered in the main or the skid register.
// The phase register is the only loop; the last byte of a URL returns it to the scheme phase.
// Synchronous active-high reset returns the machine to the scheme phase and empties the
// result buffer. Results sit in a main register backed by a skid register, so one byte
// is still taken while a result is stalled; req_chan.ready drops only when both are full.
`default_nettype none

module url_component_tagger (
   input  wire         clock,
   input  wire         reset,
   uct_req_if.sink     req_chan,
   uct_rsp_if.source   rsp_chan
);

   localparam logic [3:0] PH_SCHEME = 4'd0;
   localparam logic [3:0] PH_SLASH1 = 4'd1;
   localparam logic [3:0] PH_SLASH2 = 4'd2;
   localparam logic [3:0] PH_HOST0  = 4'd3;
   localparam logic [3:0] PH_HOST   = 4'd4;
   localparam logic [3:0] PH_BHOST  = 4'd5;
   localparam logic [3:0] PH_AFTERB = 4'd6;
   localparam logic [3:0] PH_PORT   = 4'd7;
   localparam logic [3:0] PH_PATH   = 4'd8;
   localparam logic [3:0] PH_QUERY  = 4'd9;
   localparam logic [3:0] PH_FRAG   = 4'd10;
   localparam logic [3:0] PH_ERROR  = 4'd11;

   logic [3:0]                   phase_ff, phase_in;
   logic [uct_pkg::STATUS_W-1:0] error_ff, error_in;

   logic [3:0]                   phase_next;
   logic [uct_pkg::STATUS_W-1:0] error_next;
   logic [uct_pkg::BYTE_W-1:0]   c;
   uct_pkg::rsp_item_type        item;

   uct_pkg::rsp_item_type        out_ff, out_in, skid_ff, skid_in;
   logic                         out_valid_ff, out_valid_in;
   logic                         skid_valid_ff, skid_valid_in;
   logic                         push, pop;

   assign c = req_chan.in_byte;

   // Tag the current byte and work out where the phase goes.
   always_comb begin
      phase_next      = phase_ff;
      error_next      = error_ff;
      item.out_byte   = c;
      item.out_tag    = uct_pkg::TAG_DROP;
      item.out_last   = req_chan.in_last;
      item.out_status = uct_pkg::ST_OK;

      case (phase_ff)
         PH_SCHEME: begin
            if (c == uct_pkg::CHAR_COLON) begin
               item.out_tag = uct_pkg::TAG_DELIM;
               phase_next   = PH_SLASH1;
            end else begin
               item.out_tag = uct_pkg::TAG_SCHEME;
               if (c >= uct_pkg::CHAR_UPPER_A && c <= uct_pkg::CHAR_UPPER_Z) begin
                  item.out_byte = c | uct_pkg::CASE_BIT;
               end
            end
         end
         PH_SLASH1, PH_SLASH2: begin
            if (c == uct_pkg::CHAR_SLASH) begin
               item.out_tag = uct_pkg::TAG_DELIM;
               phase_next   = (phase_ff == PH_SLASH1) ? PH_SLASH2 : PH_HOST0;
            end else begin
               phase_next = PH_ERROR;
               error_next = uct_pkg::ST_SLASHES;
            end
         end
         PH_HOST0, PH_HOST: begin
            if (phase_ff == PH_HOST0 && c == uct_pkg::CHAR_LBRACKET) begin
               item.out_tag = uct_pkg::TAG_HOST;
               phase_next   = PH_BHOST;
            end else if (c == uct_pkg::CHAR_COLON) begin
               item.out_tag = uct_pkg::TAG_DELIM;
               phase_next   = PH_PORT;
            end else if (c == uct_pkg::CHAR_SLASH) begin
               item.out_tag = uct_pkg::TAG_DELIM;
               phase_next   = PH_PATH;
            end else begin
               item.out_tag = uct_pkg::TAG_HOST;
               phase_next   = PH_HOST;
            end
         end
         PH_BHOST: begin
            item.out_tag = uct_pkg::TAG_HOST;
            if (c == uct_pkg::CHAR_RBRACKET) begin
               phase_next = PH_AFTERB;
            end
         end
         PH_AFTERB: begin
            if (c == uct_pkg::CHAR_COLON) begin
               item.out_tag = uct_pkg::TAG_DELIM;
               phase_next   = PH_PORT;
            end else if (c == uct_pkg::CHAR_SLASH) begin
               item.out_tag = uct_pkg::TAG_DELIM;
               phase_next   = PH_PATH;
            end else begin
               phase_next = PH_ERROR;
               error_next = uct_pkg::ST_BRACKET;
            end
         end
         PH_PORT: begin
            if (c == uct_pkg::CHAR_SLASH) begin
               item.out_tag = uct_pkg::TAG_DELIM;
               phase_next   = PH_PATH;
            end else begin
               item.out_tag = uct_pkg::TAG_PORT;
            end
         end
         PH_PATH: begin
            if (c == uct_pkg::CHAR_QUESTION) begin
               item.out_tag = uct_pkg::TAG_DELIM;
               phase_next   = PH_QUERY;
            end else if (c == uct_pkg::CHAR_HASH) begin
               item.out_tag = uct_pkg::TAG_DELIM;
               phase_next   = PH_FRAG;
            end else begin
               item.out_tag = uct_pkg::TAG_PATH;
            end
         end
         PH_QUERY: begin
            if (c == uct_pkg::CHAR_HASH) begin
               item.out_tag = uct_pkg::TAG_DELIM;
               phase_next   = PH_FRAG;
            end else begin
               item.out_tag = uct_pkg::TAG_QUERY;
            end
         end
         PH_FRAG: begin
            item.out_tag = uct_pkg::TAG_FRAG;
         end
         default: begin
            phase_next = PH_ERROR;
         end
      endcase

      // The status is judged on the phase this byte leaves behind.
      if (req_chan.in_last) begin
         if (phase_next == PH_ERROR) begin
            item.out_status = error_next;
         end else if (phase_next == PH_SCHEME) begin
            item.out_status = uct_pkg::ST_NOCOLON;
         end else if (phase_next == PH_SLASH1 || phase_next == PH_SLASH2) begin
            item.out_status = uct_pkg::ST_SLASHES;
         end else begin
            item.out_status = uct_pkg::ST_OK;
         end
      end
   end

   assign req_chan.ready = !skid_valid_ff;
   assign push           = req_chan.valid && req_chan.ready;
   assign pop            = out_valid_ff && rsp_chan.ready;

   always_comb begin
      phase_in = phase_ff;
      error_in = error_ff;
      if (push) begin
         if (req_chan.in_last) begin
            phase_in = PH_SCHEME;
            error_in = uct_pkg::ST_OK;
         end else begin
            phase_in = phase_next;
            error_in = error_next;
         end
      end
   end

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_in = item;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff) begin
            out_in       = item;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = item;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SCHEME;
         error_ff      <= uct_pkg::ST_OK;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         error_ff      <= error_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.out_byte   = out_ff.out_byte;
   assign rsp_chan.out_tag    = out_ff.out_tag;
   assign rsp_chan.out_last   = out_ff.out_last;
   assign rsp_chan.out_status = out_ff.out_status;

endmodule

`default_nettype wire

[design/uct_checker.sv]
// Port-level assertions for the URL component tagger and the bind that attaches them.
`default_nettype none

module uct_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               rsp_valid,
   input wire                               rsp_ready,
   input wire [uct_pkg::BYTE_W-1:0]         out_byte,
   input wire [uct_pkg::TAG_W-1:0]          out_tag,
   input wire                               out_last,
   input wire [uct_pkg::STATUS_W-1:0]       out_status
);

   // A stalled result transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(out_tag)
         && $stable(out_last) && $stable(out_status))
      else $error("stalled result changed");

   // Only the final byte of a URL carries a status.
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !out_last |-> out_status == uct_pkg::ST_OK)
      else $error("status on a byte that is not the last");

   // Scheme bytes leave lowercased.
   a_scheme_lower: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_tag == uct_pkg::TAG_SCHEME |->
         (out_byte < uct_pkg::CHAR_UPPER_A || out_byte > uct_pkg::CHAR_UPPER_Z))
      else $error("uppercase byte tagged as scheme");

   // A delimiter tag is given only to a separator character.
   a_delim_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_tag == uct_pkg::TAG_DELIM |->
         (out_byte == uct_pkg::CHAR_COLON || out_byte == uct_pkg::CHAR_SLASH ||
          out_byte == uct_pkg::CHAR_QUESTION || out_byte == uct_pkg::CHAR_HASH))
      else $error("delimiter tag on a non-separator byte");

endmodule

bind url_component_tagger uct_checker u_uct_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .out_byte   (rsp_chan.out_byte),
   .out_tag    (rsp_chan.out_tag),
   .out_last   (rsp_chan.out_last),
   .out_status (rsp_chan.out_status)
);

`default_nettype wire
